@@ hw/rtl/sct_pkg.sv @@
// Shared types and constants for the counting semaphore table.
package sct_pkg;

   localparam int NUM_SEMS  = 64;
   localparam int SEM_IDX_W = 6;
   localparam int VALUE_W   = 16;
   localparam int COUNT_W   = 15;
   localparam int GRP_SIZE  = 8;
   localparam int GRP_NUM   = NUM_SEMS / GRP_SIZE;
   localparam int GRP_IDX_W = 3;

   typedef enum logic [2:0] {
      OP_CREATE   = 3'd0,
      OP_DELETE   = 3'd1,
      OP_RESET    = 3'd2,
      OP_SIGNAL   = 3'd3,
      OP_SIGNAL_N = 3'd4,
      OP_WAIT     = 3'd5,
      OP_TRY_WAIT = 3'd6,
      OP_READ     = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_BLOCK    = 2'd3
   } status_type;

   // lowest free id, as tracked by the allocator
   typedef struct packed {
      logic                 any;
      logic [SEM_IDX_W-1:0] id;
   } free_type;

   // in-use bit update
   typedef struct packed {
      logic                 set;
      logic                 clr;
      logic [SEM_IDX_W-1:0] idx;
   } use_upd_type;

   // value store write
   typedef struct packed {
      logic                 we;
      logic [SEM_IDX_W-1:0] addr;
      logic [VALUE_W-1:0]   data;
   } val_wr_type;

   typedef struct packed {
      status_type           status;
      logic [SEM_IDX_W-1:0] new_id;
      logic [VALUE_W-1:0]   value_bits;
      logic                 must_block;
      logic [COUNT_W-1:0]   wake_count;
      logic                 wake_all;
      logic                 wake_reason;
   } rsp_type;

endpackage

@@ hw/rtl/sct_value_ram.sv @@
// Generic single-port-write, registered-read RAM for semaphore values.
module sct_value_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/sct_alloc.sv @@
// In-use bits and registered lowest-free-id search.
module sct_alloc (
   input  logic                          clock,
   input  logic                          reset,
   input  sct_pkg::use_upd_type          upd,
   input  logic [sct_pkg::SEM_IDX_W-1:0] lookup_idx,
   output logic                          id_live,
   output sct_pkg::free_type             free
);
   import sct_pkg::*;

   logic [NUM_SEMS-1:0]  in_use_ff, in_use_in;
   free_type             free_ff, free_in;
   logic [GRP_NUM-1:0]   grp_any;
   logic [GRP_IDX_W-1:0] grp_low [GRP_NUM];

   always_comb begin
      in_use_in = in_use_ff;
      if (upd.set) in_use_in[upd.idx] = 1'b1;
      if (upd.clr) in_use_in[upd.idx] = 1'b0;
   end

   // two-level priority search: lowest free slot in each group of eight,
   // then lowest group holding a free slot
   always_comb begin
      for (int g = 0; g < GRP_NUM; g++) begin
         grp_any[g] = 1'b0;
         grp_low[g] = '0;
         for (int b = GRP_SIZE - 1; b >= 0; b--) begin
            if (!in_use_ff[g*GRP_SIZE + b]) begin
               grp_any[g] = 1'b1;
               grp_low[g] = GRP_IDX_W'(b);
            end
         end
      end
      free_in = '0;
      for (int g = GRP_NUM - 1; g >= 0; g--) begin
         if (grp_any[g]) begin
            free_in.any = 1'b1;
            free_in.id  = {GRP_IDX_W'(g), grp_low[g]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
         free_ff   <= '0;
      end else begin
         in_use_ff <= in_use_in;
         free_ff   <= free_in;
      end
   end

   assign id_live = in_use_ff[lookup_idx];
   assign free    = free_ff;

endmodule

@@ hw/rtl/sct_exec.sv @@
// Command execute: value arithmetic, status and table updates.
module sct_exec (
   input  sct_pkg::op_type               op,
   input  logic [sct_pkg::SEM_IDX_W-1:0] id,
   input  logic [sct_pkg::COUNT_W-1:0]   count,
   input  logic [sct_pkg::VALUE_W-1:0]   old_raw,
   input  logic                          id_live,
   input  sct_pkg::free_type             free,
   output sct_pkg::rsp_type              rsp,
   output sct_pkg::val_wr_type           wr,
   output sct_pkg::use_upd_type          upd
);
   import sct_pkg::*;

   logic signed [VALUE_W:0] old_s, cnt_s, sum_n, neg_old;
   logic                    at_max, at_min, old_neg;
   logic [VALUE_W-1:0]      inc_raw, dec_raw, cnt_raw;

   assign old_s   = signed'({old_raw[VALUE_W-1], old_raw});
   assign cnt_s   = signed'({2'b00, count});
   assign sum_n   = old_s + cnt_s;
   assign neg_old = -old_s;
   assign at_max  = (old_raw == {1'b0, {(VALUE_W-1){1'b1}}});
   assign at_min  = (old_raw == {1'b1, {(VALUE_W-1){1'b0}}});
   assign old_neg = old_raw[VALUE_W-1];
   assign inc_raw = old_raw + 1'b1;
   assign dec_raw = old_raw - 1'b1;
   assign cnt_raw = {1'b0, count};

   always_comb begin
      rsp      = '0;
      rsp.status = ST_OK;
      wr       = '0;
      wr.addr  = id;
      upd      = '0;
      upd.idx  = id;
      if (op == OP_CREATE) begin
         if (free.any) begin
            rsp.new_id = free.id;
            wr.we      = 1'b1;
            wr.addr    = free.id;
            wr.data    = cnt_raw;
            upd.set    = 1'b1;
            upd.idx    = free.id;
         end else begin
            rsp.status = ST_INVALID;
         end
      end else if (!id_live) begin
         rsp.status = ST_INVALID;
      end else begin
         case (op)
            OP_DELETE: begin
               upd.clr      = 1'b1;
               rsp.wake_all = 1'b1;
            end
            OP_RESET: begin
               wr.we           = 1'b1;
               wr.data         = cnt_raw;
               rsp.wake_all    = 1'b1;
               rsp.wake_reason = 1'b1;
            end
            OP_SIGNAL: begin
               if (at_max) begin
                  rsp.status = ST_OVERFLOW;
               end else begin
                  wr.we          = 1'b1;
                  wr.data        = inc_raw;
                  rsp.wake_count = COUNT_W'(old_neg);
               end
            end
            OP_SIGNAL_N: begin
               if (sum_n > 17'sd32767) begin
                  rsp.status = ST_OVERFLOW;
               end else begin
                  wr.we   = 1'b1;
                  wr.data = sum_n[VALUE_W-1:0];
                  if (old_neg) begin
                     rsp.wake_count = (cnt_s < neg_old) ? count : neg_old[COUNT_W-1:0];
                  end
               end
            end
            OP_WAIT: begin
               if (at_min) begin
                  rsp.status = ST_OVERFLOW;
               end else begin
                  wr.we          = 1'b1;
                  wr.data        = dec_raw;
                  rsp.must_block = dec_raw[VALUE_W-1];
               end
            end
            OP_TRY_WAIT: begin
               if (at_min) begin
                  rsp.status = ST_OVERFLOW;
               end else if (dec_raw[VALUE_W-1]) begin
                  rsp.status = ST_BLOCK;
               end else begin
                  wr.we   = 1'b1;
                  wr.data = dec_raw;
               end
            end
            OP_READ: begin
               rsp.value_bits = old_raw;
            end
            default: begin
               rsp.status = ST_INVALID;
            end
         endcase
      end
   end

endmodule

@@ hw/rtl/counting_semaphore_table.sv @@
// Top level of the counting semaphore table.
//
//  channel | ports                               | dir | handshake
//  --------+-------------------------------------+-----+----------------------
//  req     | req_op, req_sem_id, req_count       | in  | req_valid / req_ready
//  rsp     | rsp_status .. rsp_wake_reason       | out | rsp_valid / rsp_ready
//
// For each command beat, the accept edge reads the value RAM at
// req_sem_id, and S_EXEC then executes and writes back the single entry.
// Execute waits while the previous result beat is still held in the output
// register; a new command is taken the cycle after execute completes.
// Reset clears the in-use bits and the free-id register; the value RAM is
// not cleared (an entry's value is only used after create wrote it).
module counting_semaphore_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [5:0]  req_sem_id,
   input  logic [14:0] req_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_new_id,
   output logic [15:0] rsp_value_bits,
   output logic        rsp_must_block,
   output logic [14:0] rsp_wake_count,
   output logic        rsp_wake_all,
   output logic        rsp_wake_reason
);
   import sct_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // command captured on accept (payload, no reset)
   op_type               cmd_op_ff;
   logic [SEM_IDX_W-1:0] cmd_id_ff;
   logic [COUNT_W-1:0]   cmd_count_ff;

   logic                 accept, commit;
   logic [VALUE_W-1:0]   old_raw;
   logic                 id_live;
   free_type             free;
   rsp_type              exec_rsp;
   val_wr_type           exec_wr, ram_wr;
   use_upd_type          exec_upd, alloc_upd;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   // execute retires only when the output register is free or draining
   assign commit    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_op_ff    <= op_type'(req_op);
         cmd_id_ff    <= req_sem_id;
         cmd_count_ff <= req_count;
      end
   end

   sct_value_ram #(
      .DEPTH (NUM_SEMS),
      .WIDTH (VALUE_W)
   ) u_value_ram (
      .clock (clock),
      .we    (ram_wr.we),
      .waddr (ram_wr.addr),
      .wdata (ram_wr.data),
      .re    (accept),
      .raddr (req_sem_id),
      .rdata (old_raw)
   );

   sct_alloc u_alloc (
      .clock      (clock),
      .reset      (reset),
      .upd        (alloc_upd),
      .lookup_idx (cmd_id_ff),
      .id_live    (id_live),
      .free       (free)
   );

   sct_exec u_exec (
      .op      (cmd_op_ff),
      .id      (cmd_id_ff),
      .count   (cmd_count_ff),
      .old_raw (old_raw),
      .id_live (id_live),
      .free    (free),
      .rsp     (exec_rsp),
      .wr      (exec_wr),
      .upd     (exec_upd)
   );

   // table updates land only on the retiring cycle
   always_comb begin
      ram_wr        = exec_wr;
      ram_wr.we     = exec_wr.we && commit;
      alloc_upd     = exec_upd;
      alloc_upd.set = exec_upd.set && commit;
      alloc_upd.clr = exec_upd.clr && commit;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (commit) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = exec_rsp;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_new_id      = rsp_ff.new_id;
   assign rsp_value_bits  = rsp_ff.value_bits;
   assign rsp_must_block  = rsp_ff.must_block;
   assign rsp_wake_count  = rsp_ff.wake_count;
   assign rsp_wake_all    = rsp_ff.wake_all;
   assign rsp_wake_reason = rsp_ff.wake_reason;

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the counting semaphore table.
`timescale 1ns / 1ps

module tb_top;
   import sct_pkg::*;

   localparam int RAND_ITEMS  = 1830;
   localparam int DEEP_WAITS  = 40;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 10;

   localparam rsp_type RSP_NONE    = '0;
   localparam rsp_type RSP_INVALID = '{ST_INVALID, 6'd0, 16'd0, 1'b0, 15'd0, 1'b0, 1'b0};

   // One row of directed stimulus. When typed is set, exp is the result
   // written out by hand; otherwise the semaphore predictor supplies it.
   typedef struct packed {
      op_type      op;
      logic [5:0]  id;
      logic [14:0] cnt;
      logic        typed;
      rsp_type     exp;
   } stim_row_type;

   localparam int DIR_ROWS = 25;
   localparam stim_row_type DIR_TAB [DIR_ROWS] = '{
      // nothing allocated yet: every addressed id is invalid
      '{OP_READ,     6'd0,  15'd0,      1'b1, RSP_INVALID},
      '{OP_DELETE,   6'd63, 15'h7fff,   1'b1, RSP_INVALID},
      // lowest free id is taken in order
      '{OP_CREATE,   6'd0,  15'd0,      1'b1, '{ST_OK, 6'd0, 16'd0, 1'b0, 15'd0, 1'b0, 1'b0}},
      '{OP_CREATE,   6'd40, 15'h7fff,   1'b1, '{ST_OK, 6'd1, 16'd0, 1'b0, 15'd0, 1'b0, 1'b0}},
      // id 1 sits at +32767: any increment overflows
      '{OP_SIGNAL,   6'd1,  15'd0,      1'b1, '{ST_OVERFLOW, 6'd0, 16'd0, 1'b0, 15'd0, 1'b0, 1'b0}},
      '{OP_SIGNAL_N, 6'd1,  15'd1,      1'b1, '{ST_OVERFLOW, 6'd0, 16'd0, 1'b0, 15'd0, 1'b0, 1'b0}},
      '{OP_READ,     6'd1,  15'd0,      1'b1, '{ST_OK, 6'd0, 16'h7fff, 1'b0, 15'd0, 1'b0, 1'b0}},
      // id 0 at zero: try-wait refuses, wait blocks, signal wakes one
      '{OP_TRY_WAIT, 6'd0,  15'd0,      1'b1, '{ST_BLOCK, 6'd0, 16'd0, 1'b0, 15'd0, 1'b0, 1'b0}},
      '{OP_WAIT,     6'd0,  15'd0,      1'b1, '{ST_OK, 6'd0, 16'd0, 1'b1, 15'd0, 1'b0, 1'b0}},
      '{OP_SIGNAL,   6'd0,  15'd0,      1'b1, '{ST_OK, 6'd0, 16'd0, 1'b0, 15'd1, 1'b0, 1'b0}},
      '{OP_WAIT,     6'd0,  15'd0,      1'b0, RSP_NONE},
      '{OP_WAIT,     6'd0,  15'd0,      1'b0, RSP_NONE},
      // signal_n wake count limited by the waiters present
      '{OP_SIGNAL_N, 6'd0,  15'd5,      1'b0, RSP_NONE},
      '{OP_TRY_WAIT, 6'd0,  15'd0,      1'b0, RSP_NONE},
      // reset wakes all, reason reset
      '{OP_RESET,    6'd0,  15'h7fff,   1'b1, '{ST_OK, 6'd0, 16'd0, 1'b0, 15'd0, 1'b1, 1'b1}},
      '{OP_READ,     6'd0,  15'd0,      1'b1, '{ST_OK, 6'd0, 16'h7fff, 1'b0, 15'd0, 1'b0, 1'b0}},
      // delete wakes all, reason deleted; the id is then unusable
      '{OP_DELETE,   6'd1,  15'd0,      1'b1, '{ST_OK, 6'd0, 16'd0, 1'b0, 15'd0, 1'b1, 1'b0}},
      '{OP_SIGNAL,   6'd1,  15'd0,      1'b1, RSP_INVALID},
      '{OP_CREATE,   6'd0,  15'h5555,   1'b1, '{ST_OK, 6'd1, 16'd0, 1'b0, 15'd0, 1'b0, 1'b0}},
      '{OP_SIGNAL_N, 6'd0,  15'd0,      1'b0, RSP_NONE},
      '{OP_READ,     6'd1,  15'h2aaa,   1'b0, RSP_NONE},
      '{OP_CREATE,   6'd63, 15'h2aaa,   1'b0, RSP_NONE},
      '{OP_WAIT,     6'd62, 15'd0,      1'b1, RSP_INVALID},
      '{OP_RESET,    6'd2,  15'd0,      1'b0, RSP_NONE},
      '{OP_SIGNAL_N, 6'd2,  15'h7fff,   1'b0, RSP_NONE}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_op;
   logic [5:0]  req_sem_id;
   logic [14:0] req_count;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_new_id;
   logic [15:0] rsp_value_bits;
   logic        rsp_must_block;
   logic [14:0] rsp_wake_count;
   logic        rsp_wake_all;
   logic        rsp_wake_reason;

   counting_semaphore_table dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_sem_id      (req_sem_id),
      .req_count       (req_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_new_id      (rsp_new_id),
      .rsp_value_bits  (rsp_value_bits),
      .rsp_must_block  (rsp_must_block),
      .rsp_wake_count  (rsp_wake_count),
      .rsp_wake_all    (rsp_wake_all),
      .rsp_wake_reason (rsp_wake_reason)
   );

   // Predictor copy of the semaphore table
   logic        sem_live [NUM_SEMS];
   logic [15:0] sem_val  [NUM_SEMS];

   rsp_type expected_rsps [$];
   int      err_count   = 0;
   int      items_sent  = 0;
   int      cycle_count = 0;
   int      burst_left  = 0;
   bit      gaps_on     = 1'b1;
   bit      hold_off_req = 1'b0;

   // Receiver stall pattern state
   int rx_mode     = 0;
   int rx_win_left = 0;
   int rx_tick     = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int exp_v);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h (cycle %0d)",
               what, got, exp_v, cycle_count);
      err_count++;
   endtask

   // Semaphore table behavior: applies one command to the local table copy
   // and returns the result beat it should produce.
   function automatic rsp_type predict_sem_cmd(input op_type op, input logic [5:0] id,
                                                input logic [14:0] cnt);
      rsp_type r;
      int      old_v;
      int      nv;
      int      c;
      bit      found;
      bit      live;
      r     = '0;
      c     = int'(cnt);
      found = 1'b0;
      live  = (int'(id) < NUM_SEMS) && sem_live[id];
      old_v = live ? int'($signed(sem_val[id])) : 0;
      r.status = ST_OK;
      if (op == OP_CREATE) begin
         r.status = ST_INVALID;
         for (int i = 0; i < NUM_SEMS && i < 64; i++) begin
            if (!found && !sem_live[i]) begin
               found       = 1'b1;
               sem_live[i] = 1'b1;
               sem_val[i]  = c[15:0];
               r.new_id    = i[5:0];
               r.status    = ST_OK;
            end
         end
      end else if (!live) begin
         r.status = ST_INVALID;
      end else begin
         case (op)
            OP_DELETE: begin
               sem_live[id] = 1'b0;   // value stays in the store
               r.wake_all   = 1'b1;
            end
            OP_RESET: begin
               sem_val[id]   = c[15:0];
               r.wake_all    = 1'b1;
               r.wake_reason = 1'b1;
            end
            OP_SIGNAL: begin
               nv = old_v + 1;
               if (nv > 32767) r.status = ST_OVERFLOW;
               else begin
                  sem_val[id] = nv[15:0];
                  if (nv <= 0) r.wake_count = 15'd1;
               end
            end
            OP_SIGNAL_N: begin
               nv = old_v + c;
               if (nv > 32767) r.status = ST_OVERFLOW;
               else begin
                  sem_val[id] = nv[15:0];
                  if (old_v < 0) begin
                     nv = (c < -old_v) ? c : -old_v;
                     r.wake_count = nv[14:0];
                  end
               end
            end
            OP_WAIT: begin
               nv = old_v - 1;
               if (nv < -32768) r.status = ST_OVERFLOW;
               else begin
                  sem_val[id] = nv[15:0];
                  if (nv < 0) r.must_block = 1'b1;
               end
            end
            OP_TRY_WAIT: begin
               nv = old_v - 1;
               if (nv < -32768) r.status = ST_OVERFLOW;
               else if (nv < 0) r.status = ST_BLOCK;
               else sem_val[id] = nv[15:0];
            end
            default: r.value_bits = sem_val[id];
         endcase
      end
      return r;
   endfunction

   // Drives one command beat at the falling edge and holds it until the
   // accept edge. Bursts of back-to-back beats are separated by random gaps.
   task automatic send_cmd(input op_type op, input logic [5:0] id, input logic [14:0] cnt,
                           input logic typed, input rsp_type typed_rsp);
      rsp_type pred;
      if (gaps_on && burst_left == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 11)) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_valid  <= 1'b1;
      req_op     <= op;
      req_sem_id <= id;
      req_count  <= cnt;
      do @(posedge clock); while (!req_ready);
      pred = predict_sem_cmd(op, id, cnt);
      expected_rsps.push_back(typed ? typed_rsp : pred);
      items_sent++;
   endtask

   task automatic issue(input op_type op, input logic [5:0] id, input logic [14:0] cnt);
      send_cmd(op, id, cnt, 1'b0, RSP_NONE);
   endtask

   // Counts lean on the edges: tiny, near the top, small, or anything.
   function automatic logic [14:0] rand_count();
      case ($urandom_range(0, 3))
         0:       return 15'($urandom_range(0, 3));
         1:       return 15'(32767 - $urandom_range(0, 3));
         2:       return 15'($urandom_range(0, 64));
         default: return 15'($urandom);
      endcase
   endfunction

   function automatic int pick_live();
      int start;
      int idx;
      start = $urandom_range(0, NUM_SEMS - 1);
      for (int k = 0; k < NUM_SEMS; k++) begin
         idx = (start + k) % NUM_SEMS;
         if (sem_live[idx]) return idx;
      end
      return -1;
   endfunction

   // Result checker: every accepted result beat against the oldest expectation
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result beat, status", rsp_status, 0);
         end else begin
            exp_r = expected_rsps.pop_front();
            if (rsp_status !== exp_r.status)
               report_mismatch("status", rsp_status, exp_r.status);
            if (rsp_new_id !== exp_r.new_id)
               report_mismatch("new_id", rsp_new_id, exp_r.new_id);
            if (rsp_value_bits !== exp_r.value_bits)
               report_mismatch("value_bits", rsp_value_bits, exp_r.value_bits);
            if (rsp_must_block !== exp_r.must_block)
               report_mismatch("must_block", rsp_must_block, exp_r.must_block);
            if (rsp_wake_count !== exp_r.wake_count)
               report_mismatch("wake_count", rsp_wake_count, exp_r.wake_count);
            if (rsp_wake_all !== exp_r.wake_all)
               report_mismatch("wake_all", rsp_wake_all, exp_r.wake_all);
            if (rsp_wake_reason !== exp_r.wake_reason)
               report_mismatch("wake_reason", rsp_wake_reason, exp_r.wake_reason);
         end
      end
   end

   // Receiver: windows of always-ready, coin-flip, one-in-four and rare
   // stalls; a long hold-off on request so the block backs up into req.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rx_tick++;
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            if (rx_win_left == 0) begin
               rx_mode     = $urandom_range(0, 3);
               rx_win_left = $urandom_range(20, 200);
            end
            rx_win_left--;
            case (rx_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= (rx_tick % 4 == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Main sequence
   initial begin
      int deep_id;
      int sel;
      int pick;
      int rand_end;
      bit hold_done;
      op_type op;

      reset      = 1'b1;
      req_valid  = 1'b0;
      req_op     = OP_CREATE;
      req_sem_id = '0;
      req_count  = '0;
      hold_done  = 1'b0;
      for (int i = 0; i < NUM_SEMS; i++) begin
         sem_live[i] = 1'b0;
         sem_val[i]  = '0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table
      for (int r = 0; r < DIR_ROWS; r++)
         send_cmd(DIR_TAB[r].op, DIR_TAB[r].id, DIR_TAB[r].cnt,
                  DIR_TAB[r].typed, DIR_TAB[r].exp);

      // Drive one semaphore well below zero with back-to-back waits, then
      // wake every waiter in one signal_n.
      deep_id = -1;
      for (int i = NUM_SEMS - 1; i >= 0; i--)
         if (!sem_live[i]) deep_id = i;
      gaps_on = 1'b0;
      issue(OP_CREATE, 6'd0, 15'd0);
      repeat (DEEP_WAITS) issue(OP_WAIT, deep_id[5:0], 15'($urandom));
      issue(OP_WAIT, deep_id[5:0], 15'd0);
      issue(OP_TRY_WAIT, deep_id[5:0], 15'd0);
      issue(OP_READ, deep_id[5:0], 15'd0);
      issue(OP_SIGNAL_N, deep_id[5:0], 15'h7fff);
      issue(OP_SIGNAL, deep_id[5:0], 15'd0);
      issue(OP_DELETE, deep_id[5:0], 15'd0);
      gaps_on = 1'b1;

      // Random part: mostly command sequences on live semaphores,
      // with allocation bursts, frees and noise mixed in.
      rand_end = items_sent + RAND_ITEMS;
      while (items_sent < rand_end) begin
         if (!hold_done && items_sent > rand_end - RAND_ITEMS / 2) begin
            hold_done    = 1'b1;
            hold_off_req = 1'b1;
         end
         sel  = $urandom_range(0, 99);
         pick = pick_live();
         if (sel < 45) begin
            if (pick < 0) issue(OP_CREATE, 6'($urandom), rand_count());
            else repeat ($urandom_range(1, 8)) begin
               op = op_type'($urandom_range(OP_RESET, OP_READ));
               issue(op, pick[5:0], rand_count());
            end
         end else if (sel < 60) begin
            // allocation burst, runs into a full table now and then
            repeat ($urandom_range(1, 10)) issue(OP_CREATE, 6'($urandom), rand_count());
         end else if (sel < 72) begin
            repeat ($urandom_range(1, 12)) begin
               pick = pick_live();
               if (pick >= 0) issue(OP_DELETE, pick[5:0], rand_count());
            end
         end else if (sel < 82) begin
            // park near the top, then push past it
            if (pick < 0) issue(OP_CREATE, 6'($urandom), 15'(32767 - $urandom_range(0, 3)));
            else begin
               issue(OP_RESET, pick[5:0], 15'(32767 - $urandom_range(0, 3)));
               repeat ($urandom_range(1, 4))
                  issue($urandom_range(0, 1) ? OP_SIGNAL : OP_SIGNAL_N, pick[5:0],
                        rand_count());
               issue(OP_READ, pick[5:0], rand_count());
            end
         end else if (sel < 85) begin
            // free everything
            for (int i = 0; i < NUM_SEMS; i++)
               if (sem_live[i]) issue(OP_DELETE, 6'(i), rand_count());
         end else begin
            // noise: any op, any id, any count
            repeat ($urandom_range(1, 5))
               issue(op_type'($urandom_range(0, 7)), 6'($urandom), 15'($urandom));
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (err_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
